// ===== rtl/nqh_pkg.sv =====
// ----------------------------------------------------------------------------
// nqh_pkg
// Shared types and constants for the note quantizer and humanizer.
// ----------------------------------------------------------------------------
package nqh_pkg;

    typedef enum logic [1:0] {
        REG_GRID     = 2'd0,
        REG_STRENGTH = 2'd1,
        REG_HUMANIZE = 2'd2,
        REG_UNUSED   = 2'd3
    } nqh_reg_t;

    typedef struct packed {
        logic        neg;
        logic [23:0] mag;
    } nqh_unit_t;

    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 17;
    localparam int SIDE_W    = 78;

    localparam logic [63:0] HASH_C1   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] HASH_C2   = 64'hc4ceb9fe1a85ec53;
    localparam logic [15:0] SALT_TICK = 16'hC401;
    localparam logic [15:0] SALT_VEL  = 16'hC402;

    localparam logic [16:0] Q16_ONE   = 17'd65536;
    localparam logic [17:0] RECIP25   = 18'd167773;
    localparam logic [59:0] TICK_BIAS = 60'd25 << 39;
    localparam logic [43:0] VEL_BIAS  = 44'd25 << 25;
    localparam logic [30:0] TICK_MAX  = 31'h7FFFFFFF;
    localparam logic [14:0] VEL_MAX   = 15'd24576;

endpackage

// ===== rtl/nqh_div.sv =====
// ----------------------------------------------------------------------------
// nqh_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module nqh_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [nqh_pkg::DIV_NUM_W-1:0]   num,
    input  logic [nqh_pkg::DIV_DEN_W-1:0]   den,
    input  logic [nqh_pkg::SIDE_W-1:0]      side_in,
    output logic                            out_valid,
    output logic [nqh_pkg::DIV_NUM_W-2:0]   quo,
    output logic [nqh_pkg::SIDE_W-1:0]      side_out
);
    import nqh_pkg::*;

    localparam int DEPTH = DIV_NUM_W;

    logic                 vld_reg  [DEPTH];
    logic [DIV_NUM_W-1:0] num_reg  [DEPTH];
    logic [DIV_DEN_W-1:0] rem_reg  [DEPTH];
    logic [DIV_NUM_W-1:0] quo_reg  [DEPTH];
    logic [SIDE_W-1:0]    side_reg [DEPTH];

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_stage
            logic                 vld_prev;
            logic [DIV_NUM_W-1:0] num_prev;
            logic [DIV_DEN_W-1:0] rem_prev;
            logic [DIV_NUM_W-1:0] quo_prev;
            logic [SIDE_W-1:0]    side_prev;
            logic [DIV_DEN_W:0]   trial;
            logic                 ge;
            logic [DIV_DEN_W-1:0] rem_next;
            logic [DIV_NUM_W-1:0] quo_next;

            if (k == 0) begin : g_first
                assign vld_prev  = in_valid;
                assign num_prev  = num;
                assign rem_prev  = '0;
                assign quo_prev  = '0;
                assign side_prev = side_in;
            end
            else begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign num_prev  = num_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign quo_prev  = quo_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            always_comb
            begin
                trial    = {rem_prev, num_prev[DIV_NUM_W-1-k]};
                ge       = trial >= {1'b0, den};
                rem_next = ge ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
                quo_next = {quo_prev[DIV_NUM_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k]  <= num_prev;
                    rem_reg[k]  <= rem_next;
                    quo_reg[k]  <= quo_next;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DEPTH-1];
    assign quo       = quo_reg[DEPTH-1][DIV_NUM_W-2:0];
    assign side_out  = side_reg[DEPTH-1];

endmodule

// ===== rtl/nqh_hash.sv =====
// ----------------------------------------------------------------------------
// nqh_hash
// Four-stage 64-bit mix hash of an id and salt, giving a signed unit value.
// ----------------------------------------------------------------------------
module nqh_hash (
    input  logic                  clk,
    input  logic                  en,
    input  logic [31:0]           id,
    input  logic [15:0]           salt,
    output nqh_pkg::nqh_unit_t    unit
);
    import nqh_pkg::*;

    logic [63:0] lo1_reg;
    logic [31:0] hi1_reg;
    logic [63:0] v2_reg;
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    nqh_unit_t   unit_reg;

    logic [31:0] a;
    logic [63:0] hi1_full;
    logic [63:0] p_sum;
    logic [63:0] lh_full;
    logic [63:0] hl_full;
    logic [63:0] q_sum;
    logic [23:0] h;
    nqh_unit_t   unit_next;

    always_comb
    begin
        a         = id ^ {16'h0, salt};
        hi1_full  = a * HASH_C1[63:32];
        p_sum     = lo1_reg + {hi1_reg, 32'h0};
        lh_full   = v2_reg[31:0] * HASH_C2[63:32];
        hl_full   = v2_reg[63:32] * HASH_C2[31:0];
        q_sum     = ll_reg + {32'(lh_reg + hl_reg), 32'h0};
        h         = q_sum[23:0] ^ q_sum[56:33];
        unit_next.neg = ~h[23];
        unit_next.mag = h[23] ? {h[22:0], 1'b1} : ~{h[22:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo1_reg  <= a * HASH_C1[31:0];
            hi1_reg  <= hi1_full[31:0];
            v2_reg   <= p_sum ^ (p_sum >> 33);
            ll_reg   <= v2_reg[31:0] * HASH_C2[31:0];
            lh_reg   <= lh_full[31:0];
            hl_reg   <= hl_full[31:0];
            unit_reg <= unit_next;
        end
    end

    assign unit = unit_reg;

endmodule

// ===== rtl/note_quantize_humanize.sv =====
// ----------------------------------------------------------------------------
// note_quantize_humanize
// Snaps note ticks toward a grid and adds hashed jitter to tick and velocity.
// ----------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   s_*       in         tvalid/tready      id, recorded tick, recorded velocity
//   m_*       out        tvalid/tready      edited tick, edited velocity
//   cfg_*     in         cfg_we             register index and data
//
// One event enters per cycle while the skid register is empty; each result passes
// through the 33-stage grid divider, nine arithmetic stages and the output
// register. A skid register follows the output register; the pipeline holds
// only when the skid register is full. Reset clears only valid bits and sets
// the configuration registers to grid 1, strength 0 and humanize 0.
module note_quantize_humanize (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // event_id, recorded_tick, recorded_velocity, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // edited_tick, edited_velocity, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import nqh_pkg::*;

    logic [15:0] grid_reg;
    logic [16:0] strength_reg;
    logic [16:0] humanize_reg;
    logic [15:0] g_eff;
    logic [16:0] s_eff;
    logic [16:0] hum_eff;

    logic        en;
    logic        div_valid;
    logic [31:0] div_quo;
    logic [SIDE_W-1:0] div_side;
    nqh_unit_t   unit_t;
    nqh_unit_t   unit_v;

    logic [9:1]  vld_reg;
    logic [32:0] p1_near_reg;
    logic [30:0] p1_t_reg;
    logic [14:0] p1_v_reg;
    logic        p2_dneg_reg;
    logic [15:0] p2_dmag_reg;
    logic [30:0] p2_t_reg;
    logic [14:0] p2_v_reg;
    logic        p3_dneg_reg;
    logic [32:0] p3_prod_reg;
    logic [30:0] p3_t_reg;
    logic [14:0] p3_v_reg;
    logic [31:0] p4_quant_reg;
    logic [14:0] p4_v_reg;
    logic [31:0] p5_quant_reg;
    logic [14:0] p5_v_reg;
    logic        p5_tneg_reg;
    logic        p5_vneg_reg;
    logic [40:0] p5_mt_reg;
    logic [40:0] p5_mv_reg;
    logic [31:0] p6_quant_reg;
    logic [14:0] p6_v_reg;
    logic        p6_tneg_reg;
    logic        p6_vneg_reg;
    logic [56:0] p6_mt_reg;
    logic [42:0] p6_mv_reg;
    logic [31:0] p7_quant_reg;
    logic [14:0] p7_v_reg;
    logic        p7_tneg_reg;
    logic        p7_vneg_reg;
    logic [19:0] p7_yt_reg;
    logic [17:0] p7_yv_reg;
    logic [31:0] p8_quant_reg;
    logic [14:0] p8_v_reg;
    logic        p8_tneg_reg;
    logic        p8_vneg_reg;
    logic [15:0] p8_qt_reg;
    logic [13:0] p8_qv_reg;
    logic [30:0] p9_tick_reg;
    logic [14:0] p9_vel_reg;

    logic [47:0] near_full;
    logic [33:0] round_sum;
    logic [17:0] shift_amt;
    logic [59:0] yt_sum;
    logic [43:0] yv_sum;
    logic [37:0] qt_full;
    logic [35:0] qv_full;
    logic signed [33:0] tick_sum;
    logic signed [16:0] vel_sum;
    logic [30:0] tick_next;
    logic [14:0] vel_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [45:0] out_data_reg;
    logic [45:0] out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [45:0] skid_data_reg;
    logic [45:0] skid_data_next;
    logic        push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg     <= 16'd1;
            strength_reg <= '0;
            humanize_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID:     grid_reg     <= cfg_data[15:0];
                REG_STRENGTH: strength_reg <= cfg_data;
                REG_HUMANIZE: humanize_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign g_eff   = (grid_reg == '0) ? 16'd1 : grid_reg;
    assign s_eff   = (strength_reg > Q16_ONE) ? Q16_ONE : strength_reg;
    assign hum_eff = (humanize_reg > Q16_ONE) ? Q16_ONE : humanize_reg;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    nqh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .num       ({1'b0, s_tdata[62:32], 1'b0} + {17'h0, g_eff}),
        .den       ({g_eff, 1'b0}),
        .side_in   (s_tdata[77:0]),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    nqh_hash u_hash_tick (
        .clk  (clk),
        .en   (en),
        .id   (div_side[31:0]),
        .salt (SALT_TICK),
        .unit (unit_t)
    );

    nqh_hash u_hash_vel (
        .clk  (clk),
        .en   (en),
        .id   (div_side[31:0]),
        .salt (SALT_VEL),
        .unit (unit_v)
    );

    always_comb
    begin
        near_full = div_quo * g_eff;
        round_sum = {1'b0, p3_prod_reg} + 34'd32768;
        shift_amt = round_sum[33:16];
        yt_sum    = p6_mt_reg * 60'd3 + TICK_BIAS;
        yv_sum    = {1'b0, p6_mv_reg} + VEL_BIAS;
        qt_full   = p7_yt_reg * RECIP25;
        qv_full   = p7_yv_reg * RECIP25;
        tick_sum  = p8_tneg_reg ? $signed({2'b0, p8_quant_reg}) - $signed({18'b0, p8_qt_reg})
                                : $signed({2'b0, p8_quant_reg}) + $signed({18'b0, p8_qt_reg});
        vel_sum   = p8_vneg_reg ? $signed({2'b0, p8_v_reg}) - $signed({3'b0, p8_qv_reg})
                                : $signed({2'b0, p8_v_reg}) + $signed({3'b0, p8_qv_reg});
        if (tick_sum < 0)
        begin
            tick_next = '0;
        end
        else if (tick_sum > $signed({3'b0, TICK_MAX}))
        begin
            tick_next = TICK_MAX;
        end
        else
        begin
            tick_next = tick_sum[30:0];
        end
        if (vel_sum < 0)
        begin
            vel_next = '0;
        end
        else if (vel_sum > $signed({2'b0, VEL_MAX}))
        begin
            vel_next = VEL_MAX;
        end
        else
        begin
            vel_next = vel_sum[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:1], div_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_near_reg  <= near_full[32:0];
            p1_t_reg     <= div_side[62:32];
            p1_v_reg     <= div_side[77:63];

            p2_dneg_reg  <= p1_near_reg < {2'b0, p1_t_reg};
            p2_dmag_reg  <= (p1_near_reg < {2'b0, p1_t_reg})
                            ? 16'({2'b0, p1_t_reg} - p1_near_reg)
                            : 16'(p1_near_reg - {2'b0, p1_t_reg});
            p2_t_reg     <= p1_t_reg;
            p2_v_reg     <= p1_v_reg;

            p3_dneg_reg  <= p2_dneg_reg;
            p3_prod_reg  <= p2_dmag_reg * s_eff;
            p3_t_reg     <= p2_t_reg;
            p3_v_reg     <= p2_v_reg;

            p4_quant_reg <= p3_dneg_reg ? 32'({1'b0, p3_t_reg} - {14'b0, shift_amt})
                                        : 32'({1'b0, p3_t_reg} + {14'b0, shift_amt});
            p4_v_reg     <= p3_v_reg;

            p5_quant_reg <= p4_quant_reg;
            p5_v_reg     <= p4_v_reg;
            p5_tneg_reg  <= unit_t.neg;
            p5_vneg_reg  <= unit_v.neg;
            p5_mt_reg    <= unit_t.mag * hum_eff;
            p5_mv_reg    <= unit_v.mag * hum_eff;

            p6_quant_reg <= p5_quant_reg;
            p6_v_reg     <= p5_v_reg;
            p6_tneg_reg  <= p5_tneg_reg;
            p6_vneg_reg  <= p5_vneg_reg;
            p6_mt_reg    <= p5_mt_reg * g_eff;
            p6_mv_reg    <= p5_mv_reg * 43'd3;

            p7_quant_reg <= p6_quant_reg;
            p7_v_reg     <= p6_v_reg;
            p7_tneg_reg  <= p6_tneg_reg;
            p7_vneg_reg  <= p6_vneg_reg;
            p7_yt_reg    <= yt_sum[59:40];
            p7_yv_reg    <= yv_sum[43:26];

            p8_quant_reg <= p7_quant_reg;
            p8_v_reg     <= p7_v_reg;
            p8_tneg_reg  <= p7_tneg_reg;
            p8_vneg_reg  <= p7_vneg_reg;
            p8_qt_reg    <= qt_full[37:22];
            p8_qv_reg    <= qv_full[35:22];

            p9_tick_reg  <= tick_next;
            p9_vel_reg   <= vel_next;
        end
    end

    assign push = en & vld_reg[9];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next  = push;
                out_data_next   = {p9_vel_reg, p9_tick_reg};
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = {p9_vel_reg, p9_tick_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_data_reg};

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds data while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[45:31] <= VEL_MAX))
        else $error("edited velocity above its maximum");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for note_quantize_humanize: grid snap, strength pull and
// hashed jitter are predicted per event and compared against every result.
// ----------------------------------------------------------------------------
module tb;
    import nqh_pkg::*;

    typedef struct {
        logic [31:0] id;
        logic [30:0] tick;
        logic [14:0] vel;
    } note_t;

    typedef struct {
        logic [30:0] tick;
        logic [14:0] vel;
    } edit_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    note_t       notes_pending[$];
    edit_t       edits_due[$];
    note_t       note_on_bus;
    logic [15:0] grid_now;
    logic [16:0] strength_now;
    logic [16:0] humanize_now;
    int          send_gap;
    int          take_gap;
    int          hold_left;
    bit          hold_req;
    bit          hold_done;
    bit          no_idle;
    int          errors;
    int          notes_sent;
    int          edits_seen;
    longint      cycles;

    note_quantize_humanize dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] mix64(logic [63:0] v);
        v = v ^ (v >> 33);
        v = v * HASH_C1;
        v = v ^ (v >> 33);
        v = v * HASH_C2;
        v = v ^ (v >> 33);
        return v;
    endfunction

    function automatic longint jitter_unit(logic [31:0] id, logic [15:0] salt);
        logic [63:0] h;
        h = mix64({32'd0, id} ^ {48'd0, salt}) & 64'hFFFFFF;
        return longint'(2 * h) - 64'sd16777215;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic edit_t edit_note(note_t n);
        edit_t  e;
        longint g;
        longint s;
        longint hum;
        longint t;
        longint nearest;
        longint tk;
        longint vl;
        g = (grid_now == 0) ? 1 : longint'(grid_now);
        s = (strength_now > Q16_ONE) ? 65536 : longint'(strength_now);
        hum = (humanize_now > Q16_ONE) ? 65536 : longint'(humanize_now);
        t = longint'(n.tick);
        nearest = ((2 * t + g) / (2 * g)) * g;
        tk = t + round_div((nearest - t) * s, 65536);
        tk = tk + round_div(jitter_unit(n.id, SALT_TICK) * hum * g * 3, 64'sd25 << 40);
        if (tk < 0) tk = 0;
        if (tk > 64'sd2147483647) tk = 64'sd2147483647;
        vl = longint'(n.vel) + round_div(jitter_unit(n.id, SALT_VEL) * hum * 3, 64'sd25 << 26);
        if (vl < 0) vl = 0;
        if (vl > 24576) vl = 24576;
        e.tick = tk[30:0];
        e.vel = vl[14:0];
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                edits_due.push_back(edit_note(note_on_bus));
                notes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (notes_pending.size() > 0)
                begin
                    note_on_bus = notes_pending.pop_front();
                    s_tdata <= {2'd0, note_on_bus.vel, note_on_bus.tick, note_on_bus.id};
                    s_tvalid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        edit_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                edits_seen++;
                if (edits_due.size() == 0)
                begin
                    $error("unexpected result tick=%0d vel=%0d", m_tdata[30:0], m_tdata[45:31]);
                    errors++;
                end
                else
                begin
                    want = edits_due.pop_front();
                    if (m_tdata[30:0] !== want.tick)
                    begin
                        $error("edited_tick expected %0d actual %0d", want.tick, m_tdata[30:0]);
                        errors++;
                    end
                    if (m_tdata[45:31] !== want.vel)
                    begin
                        $error("edited_velocity expected %0d actual %0d", want.vel,
                               m_tdata[45:31]);
                        errors++;
                    end
                end
                take_gap = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(nqh_reg_t idx, logic [16:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_GRID:     grid_now = value[15:0];
            REG_STRENGTH: strength_now = value;
            REG_HUMANIZE: humanize_now = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_note(logic [31:0] id, logic [30:0] tick, logic [14:0] vel);
        note_t n;
        n.id = id;
        n.tick = tick;
        n.vel = vel;
        notes_pending.push_back(n);
    endtask

    task automatic add_random(int count);
        logic [30:0] tk;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: tk = 31'($urandom_range(0, 200));
                1: tk = 31'h7FFFFFFF - 31'($urandom_range(0, 70000));
                2: tk = 31'($urandom_range(0, 1000000));
                default: tk = 31'($urandom);
            endcase
            add_note($urandom, tk, 15'($urandom_range(0, 32767)));
        end
    endtask

    task automatic add_edges();
        add_note(32'd0, 31'd0, 15'd0);
        add_note(32'hFFFFFFFF, 31'h7FFFFFFF, 15'h7FFF);
        add_note($urandom, 31'd0, 15'd24576);
        add_note($urandom, 31'h7FFFFFFF, 15'd0);
        add_note($urandom, 31'd32767, 15'd16384);
        add_note($urandom, 31'h2AAAAAAA, 15'h2AAA);
        add_note($urandom, 31'h55555555, 15'h5555);
        add_note($urandom, 31'd65535, 15'd24577);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (notes_pending.size() != 0 || s_tvalid || edits_due.size() != 0);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GRID;
        cfg_data = '0;
        grid_now = 16'd1;
        strength_now = 17'd0;
        humanize_now = 17'd0;
        errors = 0;
        notes_sent = 0;
        edits_seen = 0;
        cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_random(100);
        drain();

        write_reg(REG_GRID, 17'd0);
        write_reg(REG_STRENGTH, 17'h1FFFF);
        write_reg(REG_HUMANIZE, 17'h1FFFF);
        write_reg(REG_UNUSED, 17'h1FFFF);
        @(negedge clk);
        add_edges();
        add_random(150);
        drain();

        write_reg(REG_GRID, 17'd65535);
        write_reg(REG_STRENGTH, 17'd65536);
        write_reg(REG_HUMANIZE, 17'd65536);
        @(negedge clk);
        add_edges();
        add_random(150);
        hold_req = 1'b1;
        drain();

        no_idle = 1'b1;
        write_reg(REG_GRID, 17'd1000);
        write_reg(REG_STRENGTH, 17'd32768);
        write_reg(REG_HUMANIZE, 17'd20000);
        @(negedge clk);
        add_random(150);
        drain();
        no_idle = 1'b0;

        write_reg(REG_GRID, 17'd480);
        write_reg(REG_STRENGTH, 17'd0);
        write_reg(REG_HUMANIZE, 17'd65536);
        @(negedge clk);
        add_random(150);
        drain();

        write_reg(REG_GRID, 17'd7);
        write_reg(REG_STRENGTH, 17'd100000);
        write_reg(REG_HUMANIZE, 17'd5000);
        @(negedge clk);
        add_random(150);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_GRID, 17'($urandom_range(0, 65535)));
            write_reg(REG_STRENGTH, 17'($urandom_range(0, 131071)));
            write_reg(REG_HUMANIZE, 17'($urandom_range(0, 131071)));
            write_reg(REG_UNUSED, 17'($urandom_range(0, 131071)));
            @(negedge clk);
            add_random(60);
            drain();
        end

        $display("Sent %0d note events over nine register settings, grid 0 to 65535.",
                 notes_sent);
        $display("Checked %0d results, including a long output hold-off.", edits_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
